// File: sv/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the batched matrix multiply block: field
// widths, operation codes, register indexes and the engine control structs.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // Payload field widths.
  localparam int IDX_W      = 4;
  localparam int SLC_W      = 2;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 36;
  localparam int PROD_W     = 2 * VAL_W;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DIM_CNT_W  = 5;
  localparam int SLC_CNT_W  = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT  = 2'd3;

  // Register reset values.
  localparam logic [DIM_CNT_W-1:0] ROW_COUNT_RST    = 5'd16;
  localparam logic [DIM_CNT_W-1:0] INNER_COUNT_RST  = 5'd16;
  localparam logic [DIM_CNT_W-1:0] COLUMN_COUNT_RST = 5'd16;
  localparam logic [SLC_CNT_W-1:0] SLICE_COUNT_RST  = 3'd4;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ_C  = 2'd2
  } op_t;

  // Commands from the control FSM to the storage and MAC engine.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
  } eng_ctl_t;

  // Completion report from the engine.
  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] sum;
  } eng_rsp_t;

endpackage

// File: sv/bmm_in_if.sv
// ----------------------------------------------------------------------------
// bmm_in_if
// Input channel: one beat writes an A or B element or requests a C element.
// ----------------------------------------------------------------------------
interface bmm_in_if;
  import bmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic [SLC_W-1:0]        slice_index;
  logic signed [VAL_W-1:0] element_value;

  modport source (
    output valid, operation, row_index, col_index, slice_index, element_value,
    input  ready
  );

  modport sink (
    input  valid, operation, row_index, col_index, slice_index, element_value,
    output ready
  );

endinterface

// File: sv/bmm_out_if.sv
// ----------------------------------------------------------------------------
// bmm_out_if
// Result channel: one beat per input beat, carrying status and the C element.
// ----------------------------------------------------------------------------
interface bmm_out_if;
  import bmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    status;
  logic signed [SUM_W-1:0] product_sum;

  modport source (
    output valid, status, product_sum,
    input  ready
  );

  modport sink (
    input  valid, status, product_sum,
    output ready
  );

endinterface

// File: sv/bmm_cfg_if.sv
// ----------------------------------------------------------------------------
// bmm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bmm_cfg_if;
  import bmm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

// File: sv/bmm_engine.sv
// ----------------------------------------------------------------------------
// bmm_engine
// Holds the A and B element memories and walks one dot product through a
// single multiply-accumulate pipeline: address issue, memory read, multiply,
// accumulate.
// ----------------------------------------------------------------------------
module bmm_engine #(
  parameter int MAX_DIM    = 16,
  parameter int MAX_SLICES = 4,
  parameter int CNT_W      = $clog2(MAX_DIM + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bmm_pkg::eng_ctl_t                ctl,
  input  logic [bmm_pkg::IDX_W-1:0]        row_index,
  input  logic [bmm_pkg::IDX_W-1:0]        col_index,
  input  logic [bmm_pkg::SLC_W-1:0]        slice_index,
  input  logic signed [bmm_pkg::VAL_W-1:0] wr_value,
  input  logic [CNT_W-1:0]                 inner_len,
  output bmm_pkg::eng_rsp_t                rsp
);
  import bmm_pkg::*;

  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int SL_W      = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int ADDR_W    = SL_W + 2 * DIM_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Element memories, undefined until written.
  logic [VAL_W-1:0] a_mem [MEM_DEPTH];
  logic [VAL_W-1:0] b_mem [MEM_DEPTH];

  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       a_raddr;
  logic [ADDR_W-1:0]       b_raddr;

  logic [SL_W-1:0]         slice_r;
  logic [DIM_W-1:0]        row_r;
  logic [DIM_W-1:0]        col_r;
  logic [CNT_W-1:0]        len_r;
  logic [CNT_W-1:0]        k_r;
  logic [CNT_W-1:0]        k_nxt;
  logic                    issue_r;
  logic                    rd_vld_r;
  logic                    prod_vld_r;
  logic                    done_r;
  logic signed [VAL_W-1:0] a_rd_r;
  logic signed [VAL_W-1:0] b_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0] acc_r;

  // Element addresses: slice, then row, then column.
  assign wr_addr = {SL_W'(slice_index), DIM_W'(row_index), DIM_W'(col_index)};
  assign a_raddr = {slice_r, row_r, k_r[DIM_W-1:0]};
  assign b_raddr = {slice_r, k_r[DIM_W-1:0], col_r};
  assign k_nxt   = CNT_W'(k_r + 1'b1);

  // Memory write and registered read ports.
  always_ff @(posedge clk) begin
    if (ctl.wr_a) begin
      a_mem[wr_addr] <= wr_value;
    end
    if (ctl.wr_b) begin
      b_mem[wr_addr] <= wr_value;
    end
    if (issue_r) begin
      a_rd_r <= a_mem[a_raddr];
      b_rd_r <= b_mem[b_raddr];
    end
  end

  // Inner-step sequencer and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r    <= 1'b0;
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
      k_r        <= '0;
    end else begin
      rd_vld_r   <= issue_r;
      prod_vld_r <= rd_vld_r;
      done_r     <= prod_vld_r && !rd_vld_r && !issue_r;
      if (ctl.start) begin
        issue_r <= 1'b1;
        k_r     <= '0;
      end else if (issue_r) begin
        k_r <= k_nxt;
        if (k_nxt == len_r) begin
          issue_r <= 1'b0;
        end
      end
    end
  end

  // Operand coordinates for the current dot product.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      slice_r <= SL_W'(slice_index);
      row_r   <= DIM_W'(row_index);
      col_r   <= DIM_W'(col_index);
      len_r   <= inner_len;
    end
  end

  // Multiply, then accumulate at full result width.
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= PROD_W'(a_rd_r) * PROD_W'(b_rd_r);
    end
    if (ctl.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign rsp.done = done_r;
  assign rsp.sum  = acc_r;

endmodule

// File: sv/batched_matrix_multiply.sv
// ----------------------------------------------------------------------------
// batched_matrix_multiply
// Batched matrix multiply over signed Q8.8 elements. Beats write one A or B
// element or read one C element, computed on demand as an exact dot product.
//
//   Channel  Dir  Beat contents
//   in_ch    in   operation, row_index, col_index, slice_index, element_value
//   out_ch   out  status, product_sum (one beat per input beat)
//   cfg_ch   in   index, data (row, inner, column and slice counts)
//
// A write, a rejected beat or a read with zero inner size is held as the
// pending result and moves to the output register once that register is free.
// A good read first walks inner_count inner steps (inner_count limited to
// MAX_DIM) through the single multiply-accumulate pipeline, one inner step
// per cycle through the element memories, and its sum then becomes the
// pending result. One beat is in work at a time; the next input beat is
// taken as soon as the result moves to the output register, even while that
// register is stalled. Reset clears control state and restores the counts
// to their defaults; the element memories are undefined until written.
// ----------------------------------------------------------------------------
module batched_matrix_multiply #(
  parameter int MAX_DIM    = 16,
  parameter int MAX_SLICES = 4
) (
  input  logic clk,
  input  logic rst_n,
  bmm_in_if.sink    in_ch,
  bmm_out_if.source out_ch,
  bmm_cfg_if.sink   cfg_ch
);
  import bmm_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_HOLD
  } state_t;

  state_t                  state_r;
  logic [DIM_CNT_W-1:0]    row_count_r;
  logic [DIM_CNT_W-1:0]    inner_count_r;
  logic [DIM_CNT_W-1:0]    column_count_r;
  logic [SLC_CNT_W-1:0]    slice_count_r;

  logic                    res_status_r;
  logic signed [SUM_W-1:0] res_sum_r;
  logic                    out_valid_r;
  logic                    out_status_r;
  logic signed [SUM_W-1:0] out_sum_r;

  logic                    in_accept;
  logic                    out_free;
  logic                    out_load;
  logic                    row_ok;
  logic                    col_ok;
  logic                    row_in_ok;
  logic                    col_in_ok;
  logic                    slice_ok;
  logic                    item_ok;
  logic [CNT_W-1:0]        inner_len;
  eng_ctl_t                eng_ctl;
  eng_rsp_t                eng_rsp;

  // Configuration registers; the port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      inner_count_r  <= INNER_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
      slice_count_r  <= SLICE_COUNT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_ch.data;
        CFG_INNER_COUNT:  inner_count_r  <= cfg_ch.data;
        CFG_COLUMN_COUNT: column_count_r <= cfg_ch.data;
        CFG_SLICE_COUNT:  slice_count_r  <= SLC_CNT_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Effective inner length: the count register limited to the array size.
  assign inner_len = (32'(inner_count_r) > MAX_DIM) ? CNT_W'(MAX_DIM)
                                                    : CNT_W'(inner_count_r);

  // Range checks against the configured shape, each limited by the maximum.
  assign row_ok    = ({1'b0, in_ch.row_index} < row_count_r)
                     && (32'(in_ch.row_index) < MAX_DIM);
  assign col_ok    = ({1'b0, in_ch.col_index} < column_count_r)
                     && (32'(in_ch.col_index) < MAX_DIM);
  assign row_in_ok = ({1'b0, in_ch.row_index} < inner_count_r)
                     && (32'(in_ch.row_index) < MAX_DIM);
  assign col_in_ok = ({1'b0, in_ch.col_index} < inner_count_r)
                     && (32'(in_ch.col_index) < MAX_DIM);
  assign slice_ok  = ({1'b0, in_ch.slice_index} < slice_count_r)
                     && (32'(in_ch.slice_index) < MAX_SLICES);

  always_comb begin
    unique case (op_t'(in_ch.operation))
      OP_WRITE_A: item_ok = row_ok && col_in_ok && slice_ok;
      OP_WRITE_B: item_ok = row_in_ok && col_ok && slice_ok;
      OP_READ_C:  item_ok = row_ok && col_ok && slice_ok;
      default:    item_ok = 1'b0;
    endcase
  end

  // Input handshake and engine commands.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == S_HOLD) && out_free;

  assign eng_ctl.wr_a  = in_accept && item_ok && (op_t'(in_ch.operation) == OP_WRITE_A);
  assign eng_ctl.wr_b  = in_accept && item_ok && (op_t'(in_ch.operation) == OP_WRITE_B);
  assign eng_ctl.start = in_accept && item_ok && (op_t'(in_ch.operation) == OP_READ_C)
                         && (inner_len != '0);

  bmm_engine #(
    .MAX_DIM    (MAX_DIM),
    .MAX_SLICES (MAX_SLICES),
    .CNT_W      (CNT_W)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (eng_ctl),
    .row_index   (in_ch.row_index),
    .col_index   (in_ch.col_index),
    .slice_index (in_ch.slice_index),
    .wr_value    (in_ch.element_value),
    .inner_len   (inner_len),
    .rsp         (eng_rsp)
  );

  // Control FSM with the pending result and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            res_status_r <= item_ok ? STATUS_OK : STATUS_ERR;
            res_sum_r    <= '0;
            state_r      <= eng_ctl.start ? S_CALC : S_HOLD;
          end
        end
        S_CALC: begin
          if (eng_rsp.done) begin
            res_sum_r <= eng_rsp.sum;
            state_r   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_sum_r    <= res_sum_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.product_sum = out_sum_r;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for batched_matrix_multiply. A shadow copy of the
// A and B element stores and of the shape registers predicts the status and
// product sum of every accepted input beat, and every result beat is checked
// against the oldest prediction. Directed tests cover full-scale sums, the
// shape boundaries, zero and oversized registers and the unused operation
// code. Random traffic then fills matrix rows and columns and reads back the
// products under many shapes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import bmm_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 30;
  localparam int DIM_LIMIT     = 16;
  localparam int SLICE_LIMIT   = 4;
  localparam int STORE_DEPTH   = DIM_LIMIT * DIM_LIMIT * SLICE_LIMIT;

  // The operation encoding left unused by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MOST_POS = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] VAL_ONE      = 16'sh0100;
  localparam logic signed [VAL_W-1:0] VAL_MINUS_HALF = 16'shFF80;

  typedef struct {
    logic                    status;
    logic signed [SUM_W-1:0] product_sum;
  } bmm_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bmm_in_if  in_ch ();
  bmm_out_if out_ch ();
  bmm_cfg_if cfg_ch ();

  batched_matrix_multiply #(
    .MAX_DIM   (DIM_LIMIT),
    .MAX_SLICES(SLICE_LIMIT)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow element stores, with a flag per entry that records a write.
  logic signed [VAL_W-1:0] a_shadow [STORE_DEPTH];
  logic signed [VAL_W-1:0] b_shadow [STORE_DEPTH];
  bit                      a_written [STORE_DEPTH];
  bit                      b_written [STORE_DEPTH];

  // Shadow shape registers.
  logic [DIM_CNT_W-1:0] row_count_q    = ROW_COUNT_RST;
  logic [DIM_CNT_W-1:0] inner_count_q  = INNER_COUNT_RST;
  logic [DIM_CNT_W-1:0] column_count_q = COLUMN_COUNT_RST;
  logic [SLC_CNT_W-1:0] slice_count_q  = SLICE_COUNT_RST;

  bmm_result_t awaited_results [$];

  int  fail_count;
  int  cycle_count;
  int  beats_sent;
  int  reads_ok;
  int  writes_ok;
  int  rejects;
  int  shapes_applied;
  int  sink_hold;
  bit  src_steady;
  bit  snk_steady;

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Shape helpers: a register above its maximum acts as that maximum.
  // --------------------------------------------------------------------------
  function automatic int clamp_count(int value, int limit);
    return (value > limit) ? limit : value;
  endfunction

  function automatic int rows_used();
    return clamp_count(int'(row_count_q), DIM_LIMIT);
  endfunction

  function automatic int inner_used();
    return clamp_count(int'(inner_count_q), DIM_LIMIT);
  endfunction

  function automatic int cols_used();
    return clamp_count(int'(column_count_q), DIM_LIMIT);
  endfunction

  function automatic int slices_used();
    return clamp_count(int'(slice_count_q), SLICE_LIMIT);
  endfunction

  function automatic int store_addr(int slice, int row, int col);
    return (slice * DIM_LIMIT + row) * DIM_LIMIT + col;
  endfunction

  // True when the addressed element lies inside the configured shape.
  function automatic bit in_shape(logic [1:0] op, int row, int col, int slice);
    if (slice >= slices_used()) return 1'b0;
    case (op)
      OP_WRITE_A: return row < rows_used() && col < inner_used();
      OP_WRITE_B: return row < inner_used() && col < cols_used();
      OP_READ_C:  return row < rows_used() && col < cols_used();
      default:    return 1'b0;
    endcase
  endfunction

  // A read may be issued when it is rejected or every operand was written.
  function automatic bit safe_read(int row, int col, int slice);
    if (!in_shape(OP_READ_C, row, col, slice)) return 1'b1;
    for (int k = 0; k < inner_used(); k++) begin
      if (!a_written[store_addr(slice, row, k)] || !b_written[store_addr(slice, k, col)])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: applies one beat to the shadow stores and returns its result.
  // --------------------------------------------------------------------------
  function automatic bmm_result_t gemm_step(logic [1:0] op, int row, int col, int slice,
                                            logic signed [VAL_W-1:0] value);
    bmm_result_t res;
    longint      acc;
    res.status      = STATUS_ERR;
    res.product_sum = '0;
    if (!in_shape(op, row, col, slice)) begin
      rejects++;
      return res;
    end
    res.status = STATUS_OK;
    case (op)
      OP_WRITE_A: begin
        a_shadow[store_addr(slice, row, col)]  = value;
        a_written[store_addr(slice, row, col)] = 1'b1;
        writes_ok++;
      end
      OP_WRITE_B: begin
        b_shadow[store_addr(slice, row, col)]  = value;
        b_written[store_addr(slice, row, col)] = 1'b1;
        writes_ok++;
      end
      default: begin
        // Exact dot product along the inner dimension.
        acc = 0;
        for (int k = 0; k < inner_used(); k++)
          acc += longint'(a_shadow[store_addr(slice, row, k)]) *
                 longint'(b_shadow[store_addr(slice, k, col)]);
        res.product_sum = acc[SUM_W-1:0];
        reads_ok++;
      end
    endcase
    return res;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] check error: %s", $time, msg);
  endfunction

  function automatic int draw_wait(bit steady);
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MOST_NEG;
      1:       return VAL_MOST_POS;
      2:       return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Dimension register values, weighted toward small shapes.
  function automatic int pick_dim();
    case ($urandom_range(0, 19))
      0:          return 0;
      1, 2:       return DIM_LIMIT;
      3, 4:       return $urandom_range(DIM_LIMIT + 1, 31);
      5, 6, 7:    return $urandom_range(1, DIM_LIMIT);
      default:    return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_slices();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(SLICE_LIMIT + 1, 7);
      2:       return SLICE_LIMIT;
      default: return $urandom_range(1, SLICE_LIMIT);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: checks result beats and feeds accepted beats to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    bmm_result_t want;
    if (rst_n) begin
      // Result beat against the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("result beat with nothing pending: status %0b sum %0d",
                                 out_ch.status, out_ch.product_sum));
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status)
            note_failure($sformatf("status expected %0b actual %0b",
                                   want.status, out_ch.status));
          if (out_ch.product_sum !== want.product_sum)
            note_failure($sformatf("product_sum expected %0d actual %0d",
                                   want.product_sum, out_ch.product_sum));
        end
      end

      // Accepted input beat.
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(gemm_step(in_ch.operation, int'(in_ch.row_index),
                                            int'(in_ch.col_index),
                                            int'(in_ch.slice_index),
                                            in_ch.element_value));

      // Register write; the slice register keeps only its low bits.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_ROW_COUNT:    row_count_q    = cfg_ch.data;
          CFG_INNER_COUNT:  inner_count_q  = cfg_ch.data;
          CFG_COLUMN_COUNT: column_count_q = cfg_ch.data;
          CFG_SLICE_COUNT:  slice_count_q  = cfg_ch.data[SLC_CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result sink: stalls a random number of cycles after each beat.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sink_hold = draw_wait(snk_steady);
    else if (sink_hold > 0) sink_hold--;
    out_ch.ready <= (sink_hold == 0);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("batched_matrix_multiply regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Sends one input beat after a random gap and returns at its acceptance.
  task automatic send_beat(logic [1:0] op, int row, int col, int slice,
                           logic signed [VAL_W-1:0] value);
    int gap;
    gap = draw_wait(src_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.row_index     <= IDX_W'(row);
    in_ch.col_index     <= IDX_W'(col);
    in_ch.slice_index   <= SLC_W'(slice);
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // Waits until every predicted result has arrived and the block is idle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrites all four shape registers once the block has drained.
  task automatic set_shape(int rows, int inner, int cols, int slices);
    wait_idle();
    write_register(CFG_ROW_COUNT, rows);
    write_register(CFG_INNER_COUNT, inner);
    write_register(CFG_COLUMN_COUNT, cols);
    write_register(CFG_SLICE_COUNT, slices);
    shapes_applied++;
  endtask

  // Random beat of any operation and index; reads of unwritten data become writes.
  task automatic send_noise_beat();
    logic [1:0] op;
    int         row;
    int         col;
    int         slice;
    op    = 2'($urandom_range(0, 3));
    row   = $urandom_range(0, 15);
    col   = $urandom_range(0, 15);
    slice = $urandom_range(0, 3);
    if (op == OP_READ_C && !safe_read(row, col, slice)) op = OP_WRITE_B;
    send_beat(op, row, col, slice, pick_value());
  endtask

  // Fills one row of A and one column of B, reads their product, then reads
  // a few other elements whose operands are already in place.
  task automatic run_product_sequence();
    int slice;
    int row;
    int col;
    int extra;
    bit a_first;
    if (rows_used() == 0 || cols_used() == 0 || slices_used() == 0) begin
      send_noise_beat();
      return;
    end
    slice   = $urandom_range(0, slices_used() - 1);
    row     = $urandom_range(0, rows_used() - 1);
    col     = $urandom_range(0, cols_used() - 1);
    a_first = 1'($urandom_range(0, 1));
    for (int k = 0; k < inner_used(); k++) begin
      if (a_first) send_beat(OP_WRITE_A, row, k, slice, pick_value());
      send_beat(OP_WRITE_B, k, col, slice, pick_value());
      if (!a_first) send_beat(OP_WRITE_A, row, k, slice, pick_value());
    end
    send_beat(OP_READ_C, row, col, slice, pick_value());
    extra = $urandom_range(0, 3);
    for (int n = 0; n < 8 && extra > 0; n++) begin
      slice = $urandom_range(0, slices_used() - 1);
      row   = $urandom_range(0, rows_used() - 1);
      col   = $urandom_range(0, cols_used() - 1);
      if (safe_read(row, col, slice)) begin
        send_beat(OP_READ_C, row, col, slice, pick_value());
        extra--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset shape: sixteen-term sums at both ends of the output range.
  task automatic test_full_scale_sums();
    for (int k = 0; k < DIM_LIMIT; k++) begin
      send_beat(OP_WRITE_A, 15, k, 3, VAL_MOST_NEG);
      send_beat(OP_WRITE_B, k, 15, 3, VAL_MOST_NEG);
    end
    send_beat(OP_READ_C, 15, 15, 3, '0);
    for (int k = 0; k < DIM_LIMIT; k++) send_beat(OP_WRITE_B, k, 0, 3, VAL_MOST_POS);
    send_beat(OP_READ_C, 15, 0, 3, VAL_MOST_NEG);
  endtask

  // Extreme values, every operation and writes just past the inner size.
  task automatic test_directed_cases();
    set_shape(DIM_LIMIT, 2, DIM_LIMIT, SLICE_LIMIT);
    send_beat(OP_WRITE_A, 15, 0, 3, VAL_MOST_NEG);
    send_beat(OP_WRITE_A, 15, 1, 3, VAL_MOST_NEG);
    send_beat(OP_WRITE_B, 0, 15, 3, VAL_MOST_NEG);
    send_beat(OP_WRITE_B, 1, 15, 3, VAL_MOST_NEG);
    // The value field of a read is ignored.
    send_beat(OP_READ_C, 15, 15, 3, VAL_MOST_POS);
    send_beat(OP_WRITE_B, 1, 15, 3, VAL_MOST_POS);
    send_beat(OP_READ_C, 15, 15, 3, '0);
    // Mixed signs in the first slice.
    send_beat(OP_WRITE_A, 0, 0, 0, VAL_MOST_POS);
    send_beat(OP_WRITE_A, 0, 1, 0, VAL_ONE);
    send_beat(OP_WRITE_B, 0, 0, 0, VAL_MOST_NEG);
    send_beat(OP_WRITE_B, 1, 0, 0, VAL_MINUS_HALF);
    send_beat(OP_READ_C, 0, 0, 0, VAL_MOST_NEG);
    send_beat(OP_WRITE_A, 0, 2, 0, VAL_MOST_POS);
    send_beat(OP_WRITE_B, 2, 0, 0, VAL_MOST_POS);
    // The unused operation code is rejected and changes nothing.
    send_beat(OP_UNUSED, 0, 0, 0, VAL_MOST_POS);
    send_beat(OP_UNUSED, 15, 15, 3, VAL_MOST_NEG);
    send_beat(OP_READ_C, 0, 0, 0, '0);
  endtask

  // Each index one step past the configured shape.
  task automatic test_out_of_range();
    set_shape(3, 2, 3, 2);
    send_beat(OP_READ_C, 3, 0, 0, '0);
    send_beat(OP_READ_C, 0, 3, 0, '0);
    send_beat(OP_READ_C, 0, 0, 2, '0);
    send_beat(OP_WRITE_A, 3, 0, 0, VAL_ONE);
    send_beat(OP_WRITE_A, 0, 0, 2, VAL_ONE);
    send_beat(OP_WRITE_B, 0, 3, 0, VAL_ONE);
    send_beat(OP_READ_C, 0, 0, 0, '0);
  endtask

  // A zero register puts every index of its dimension out of range.
  task automatic test_zero_registers();
    set_shape(0, 2, DIM_LIMIT, SLICE_LIMIT);
    send_beat(OP_WRITE_A, 0, 0, 0, VAL_ONE);
    send_beat(OP_READ_C, 0, 0, 0, '0);
    send_beat(OP_WRITE_B, 1, 0, 0, VAL_MINUS_HALF);
    // Zero inner size: both writes fail and a read sums nothing.
    set_shape(DIM_LIMIT, 0, DIM_LIMIT, SLICE_LIMIT);
    send_beat(OP_WRITE_A, 0, 0, 0, VAL_ONE);
    send_beat(OP_WRITE_B, 0, 0, 0, VAL_ONE);
    send_beat(OP_READ_C, 5, 9, 2, '0);
    set_shape(DIM_LIMIT, 2, 0, SLICE_LIMIT);
    send_beat(OP_WRITE_B, 0, 0, 0, VAL_ONE);
    send_beat(OP_READ_C, 0, 0, 0, '0);
    send_beat(OP_WRITE_A, 0, 1, 0, VAL_MOST_NEG);
    set_shape(DIM_LIMIT, 2, DIM_LIMIT, 0);
    send_beat(OP_WRITE_A, 0, 0, 0, VAL_ONE);
    send_beat(OP_WRITE_B, 0, 0, 0, VAL_ONE);
    send_beat(OP_READ_C, 0, 0, 0, '0);
  endtask

  // Registers above their maximum act as the maximum; the slice register
  // keeps only its low three bits.
  task automatic test_above_limit();
    set_shape(31, 2, 17, 7);
    send_beat(OP_WRITE_A, 15, 1, 3, VAL_MINUS_HALF);
    send_beat(OP_READ_C, 15, 15, 3, '0);
    send_beat(OP_READ_C, 0, 0, 0, '0);
    set_shape(20, 2, 31, 12);
    send_beat(OP_WRITE_B, 0, 15, 3, VAL_ONE);
    send_beat(OP_READ_C, 15, 15, 3, '0);
  endtask

  // Random shapes, each carrying mostly product sequences and some noise.
  task automatic test_random_traffic();
    int goal;
    int epoch_goal;
    goal = beats_sent + RANDOM_ITEMS;
    while (beats_sent < goal) begin
      set_shape(pick_dim(), pick_dim(), pick_dim(), pick_slices());
      epoch_goal = beats_sent + $urandom_range(60, 200);
      while (beats_sent < epoch_goal && beats_sent < goal) begin
        src_steady = ($urandom_range(0, 4) == 0);
        snk_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0) run_product_sequence();
        else send_noise_beat();
      end
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_WRITE_A;
    in_ch.row_index     <= '0;
    in_ch.col_index     <= '0;
    in_ch.slice_index   <= '0;
    in_ch.element_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_ROW_COUNT;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_scale_sums();
    test_directed_cases();
    test_out_of_range();
    test_zero_registers();
    test_above_limit();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Covered %0d product reads, %0d element writes and %0d rejected beats",
             reads_ok, writes_ok, rejects);
    $display("across %0d shape settings, %0d check errors.", shapes_applied, fail_count);
    if (fail_count == 0) begin
      $display("batched_matrix_multiply regression: pass");
    end else begin
      $display("batched_matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule
